// ===== rtl/core/owah_pkg.sv =====
// ----------------------------------------------------------------------------
// owah_pkg
// Shared types, codes and widths of the one-wire address handoff master.
// ----------------------------------------------------------------------------
package owah_pkg;

  // timer width and the widest value it is compared against
  localparam int TIMER_BITS = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CMP_W      = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
  localparam int REG_INDEX_W = 3;

  // configuration register indexes
  localparam logic [REG_INDEX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PRES_SAMPLE    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_PRES_RECOVER   = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_READ_SAMPLE    = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_SLOT           = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_IDLE_LIMIT     = 3'd7;

  // sequencer phases
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_WAIT_HIGH    = 4'd1;
  localparam logic [3:0] PH_RESET_LOW    = 4'd2;
  localparam logic [3:0] PH_PRES_WAIT    = 4'd3;
  localparam logic [3:0] PH_PRES_RECOVER = 4'd4;
  localparam logic [3:0] PH_WRITE_ADDR   = 4'd5;
  localparam logic [3:0] PH_READ_ECHO    = 4'd6;
  localparam logic [3:0] PH_WRITE_ACK    = 4'd7;

  // input operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_STUCK_LOW   = 2'd1;
  localparam logic [1:0] ST_NO_PRESENCE = 2'd2;
  localparam logic [1:0] ST_MISMATCH    = 2'd3;

  // acknowledge bytes
  localparam logic [7:0] ACK_MATCH    = 8'h01;
  localparam logic [7:0] ACK_MISMATCH = 8'hFE;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // configuration register file
  typedef struct packed {
    logic [11:0] reset_low_us;
    logic [9:0]  presence_sample_us;
    logic [9:0]  presence_recovery_us;
    logic [5:0]  write_one_low_us;
    logic [6:0]  write_zero_low_us;
    logic [5:0]  read_sample_us;
    logic [7:0]  slot_us;
    logic [19:0] idle_wait_limit_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_us:         12'd480,
    presence_sample_us:   10'd70,
    presence_recovery_us: 10'd410,
    write_one_low_us:     6'd6,
    write_zero_low_us:    7'd60,
    read_sample_us:       6'd15,
    slot_us:              8'd70,
    idle_wait_limit_us:   20'd1000000
  };

  // sequencer state
  typedef struct packed {
    logic [3:0]            phase;
    logic [TIMER_BITS-1:0] tick_count;
    logic [2:0]            bit_index;
    logic [7:0]            address_hold;
    logic [7:0]            send_shift;
    logic [7:0]            read_shift;
    logic [1:0]            last_status;
  } seq_state_t;

  // one result word
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] echo_byte;
  } res_word_t;

endpackage

// ===== rtl/core/owah_in_if.sv =====
// ----------------------------------------------------------------------------
// owah_in_if
// Input channel: tick or start words with address and sampled line level.
// ----------------------------------------------------------------------------
interface owah_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] address;
  logic       line_level;

  modport source (output valid, op, address, line_level, input ready);
  modport sink   (input valid, op, address, line_level, output ready);
endinterface

// ===== rtl/core/owah_out_if.sv =====
// ----------------------------------------------------------------------------
// owah_out_if
// Result channel: bus drive and sequence status for each input word.
// ----------------------------------------------------------------------------
interface owah_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] echo_byte;

  modport source (output valid, drive_low, busy_res, done_res, status, echo_byte,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, status, echo_byte,
                  output ready);
endinterface

// ===== rtl/core/one_wire_address_handoff_master_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_address_handoff_master_core
// One-wire master that resets the bus, writes an address, reads its echo and
// acknowledges it, timed by microsecond tick words.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       contents
//  item      in   valid/ready     op, address, line_level
//  result    out  valid/ready     drive_low, busy_res, done_res, status, echo_byte
//  wr_*      in   wr_en only      wr_index, wr_data (register write)
//
// One word per cycle unless the result stalls; each word yields one registered result.
// The sequencer state and the result register update in the accepting cycle.
// item.ready is high while the result register is empty or being taken.
// rst (synchronous) returns the sequencer to idle and the registers to defaults.
// ----------------------------------------------------------------------------
module one_wire_address_handoff_master_core (
  input  logic                              clk,
  input  logic                              rst,
  owah_in_if.sink                           item,
  owah_out_if.source                        result,
  input  logic                              wr_en,
  input  logic [owah_pkg::REG_INDEX_W-1:0]  wr_index,
  input  logic [owah_pkg::CFG_DATA_W-1:0]   wr_data
);

  owah_pkg::cfg_t       cfg;
  owah_pkg::seq_state_t state;
  owah_pkg::seq_state_t state_next;
  owah_pkg::res_word_t  res_next;
  owah_pkg::res_word_t  res_q;
  logic                 res_valid;
  logic                 accept;

  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= owah_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        owah_pkg::REG_RESET_LOW:      cfg.reset_low_us         <= wr_data[11:0];
        owah_pkg::REG_PRES_SAMPLE:    cfg.presence_sample_us   <= wr_data[9:0];
        owah_pkg::REG_PRES_RECOVER:   cfg.presence_recovery_us <= wr_data[9:0];
        owah_pkg::REG_WRITE_ONE_LOW:  cfg.write_one_low_us     <= wr_data[5:0];
        owah_pkg::REG_WRITE_ZERO_LOW: cfg.write_zero_low_us    <= wr_data[6:0];
        owah_pkg::REG_READ_SAMPLE:    cfg.read_sample_us       <= wr_data[5:0];
        owah_pkg::REG_SLOT:           cfg.slot_us              <= wr_data[7:0];
        owah_pkg::REG_IDLE_LIMIT:     cfg.idle_wait_limit_us   <= wr_data[19:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer step
  owah_seq_step u_step (
    .cfg        (cfg),
    .cur        (state),
    .op         (item.op),
    .address    (item.address),
    .line_level (item.line_level),
    .nxt        (state_next),
    .res        (res_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: owah_pkg::PH_IDLE, default: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.drive_low = res_q.drive_low;
  assign result.busy_res  = res_q.busy_res;
  assign result.done_res  = res_q.done_res;
  assign result.status    = res_q.status;
  assign result.echo_byte = res_q.echo_byte;

endmodule

// ===== rtl/core/owah_seq_step.sv =====
// ----------------------------------------------------------------------------
// owah_seq_step
// Next-state and result logic of the handoff sequencer for one input word.
// ----------------------------------------------------------------------------
module owah_seq_step (
  input  owah_pkg::cfg_t       cfg,
  input  owah_pkg::seq_state_t cur,
  input  logic                 op,
  input  logic [7:0]           address,
  input  logic                 line_level,
  output owah_pkg::seq_state_t nxt,
  output owah_pkg::res_word_t  res
);

  logic [owah_pkg::TIMER_BITS-1:0] t;
  logic [owah_pkg::CMP_W-1:0]      t_w;
  logic [owah_pkg::CMP_W-1:0]      cur_w;
  logic [7:0]                      rs;
  logic                            done;
  logic [6:0]                      low_time;
  logic                            slot_drive;

  // saturating tick counter increment
  always_comb begin
    t     = (cur.tick_count == owah_pkg::TIMER_MAX) ? cur.tick_count
                                                    : cur.tick_count + 1'b1;
    t_w   = owah_pkg::CMP_W'(t);
    cur_w = owah_pkg::CMP_W'(cur.tick_count);
  end

  // sequencer transition
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    rs   = cur.read_shift;
    if (op == owah_pkg::OP_START) begin
      if (cur.phase == owah_pkg::PH_IDLE) begin
        nxt.address_hold = address;
        nxt.last_status  = owah_pkg::ST_OK;
        nxt.phase        = owah_pkg::PH_WAIT_HIGH;
        nxt.tick_count   = '0;
        nxt.bit_index    = '0;
      end
    end else begin
      unique case (cur.phase)
        owah_pkg::PH_WAIT_HIGH: begin
          if (cur_w >= owah_pkg::CMP_W'(cfg.idle_wait_limit_us) ||
              cur.tick_count == owah_pkg::TIMER_MAX) begin
            nxt.last_status = owah_pkg::ST_STUCK_LOW;
            nxt.phase       = owah_pkg::PH_IDLE;
            nxt.tick_count  = '0;
            nxt.bit_index   = '0;
            done            = 1'b1;
          end else if (line_level) begin
            nxt.phase      = owah_pkg::PH_RESET_LOW;
            nxt.tick_count = '0;
            nxt.bit_index  = '0;
          end else begin
            nxt.tick_count = t;
          end
        end
        owah_pkg::PH_RESET_LOW: begin
          if (t_w >= owah_pkg::CMP_W'(cfg.reset_low_us)) begin
            nxt.phase      = owah_pkg::PH_PRES_WAIT;
            nxt.tick_count = '0;
            nxt.bit_index  = '0;
          end else begin
            nxt.tick_count = t;
          end
        end
        owah_pkg::PH_PRES_WAIT: begin
          if (t_w >= owah_pkg::CMP_W'(cfg.presence_sample_us)) begin
            nxt.last_status = line_level ? owah_pkg::ST_NO_PRESENCE : owah_pkg::ST_OK;
            nxt.phase       = owah_pkg::PH_PRES_RECOVER;
            nxt.tick_count  = '0;
            nxt.bit_index   = '0;
          end else begin
            nxt.tick_count = t;
          end
        end
        owah_pkg::PH_PRES_RECOVER: begin
          if (t_w >= owah_pkg::CMP_W'(cfg.presence_recovery_us)) begin
            nxt.tick_count = '0;
            nxt.bit_index  = '0;
            if (cur.last_status != owah_pkg::ST_OK) begin
              nxt.phase = owah_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              nxt.send_shift = cur.address_hold;
              nxt.phase      = owah_pkg::PH_WRITE_ADDR;
            end
          end else begin
            nxt.tick_count = t;
          end
        end
        owah_pkg::PH_WRITE_ADDR, owah_pkg::PH_READ_ECHO, owah_pkg::PH_WRITE_ACK: begin
          // read slots sample once, at the configured sample tick
          if (cur.phase == owah_pkg::PH_READ_ECHO && line_level &&
              t_w == owah_pkg::CMP_W'(cfg.read_sample_us)) begin
            rs[cur.bit_index] = 1'b1;
          end
          nxt.read_shift = rs;
          if (t_w >= owah_pkg::CMP_W'(cfg.slot_us)) begin
            nxt.tick_count = '0;
            if (cur.bit_index != 3'd7) begin
              nxt.bit_index = cur.bit_index + 3'd1;
            end else begin
              nxt.bit_index = '0;
              if (cur.phase == owah_pkg::PH_WRITE_ADDR) begin
                nxt.read_shift = '0;
                nxt.phase      = owah_pkg::PH_READ_ECHO;
              end else if (cur.phase == owah_pkg::PH_READ_ECHO) begin
                if (rs == cur.address_hold) begin
                  nxt.send_shift  = owah_pkg::ACK_MATCH;
                  nxt.last_status = owah_pkg::ST_OK;
                end else begin
                  nxt.send_shift  = owah_pkg::ACK_MISMATCH;
                  nxt.last_status = owah_pkg::ST_MISMATCH;
                end
                nxt.phase = owah_pkg::PH_WRITE_ACK;
              end else begin
                nxt.phase = owah_pkg::PH_IDLE;
                done      = 1'b1;
              end
            end
          end else begin
            nxt.tick_count = t;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // bus drive for the coming microsecond, from the updated state
  always_comb begin
    low_time = (nxt.phase == owah_pkg::PH_READ_ECHO || nxt.send_shift[nxt.bit_index])
               ? {1'b0, cfg.write_one_low_us} : cfg.write_zero_low_us;
    slot_drive = owah_pkg::CMP_W'(nxt.tick_count) < owah_pkg::CMP_W'(low_time);
    unique case (nxt.phase)
      owah_pkg::PH_RESET_LOW:  res.drive_low = 1'b1;
      owah_pkg::PH_WRITE_ADDR,
      owah_pkg::PH_READ_ECHO,
      owah_pkg::PH_WRITE_ACK:  res.drive_low = slot_drive;
      default:                 res.drive_low = 1'b0;
    endcase
    res.busy_res  = nxt.phase != owah_pkg::PH_IDLE;
    res.done_res  = done;
    res.status    = nxt.last_status;
    res.echo_byte = nxt.read_shift;
  end

endmodule

// ===== rtl/core/owah_checker.sv =====
// ----------------------------------------------------------------------------
// owah_checker
// Port-level checks of the handoff master, bound to the top level.
// ----------------------------------------------------------------------------
module owah_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [1:0] status,
  input logic [7:0] echo_byte
);

  // no result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a finished sequence reports idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done word still reports busy");

  // bus is released whenever no sequence runs
  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && !busy_res |-> !drive_low)
    else $error("bus driven low while idle");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(drive_low) && $stable(busy_res)
      && $stable(done_res) && $stable(status) && $stable(echo_byte))
    else $error("stalled result word changed");

endmodule

bind one_wire_address_handoff_master_core owah_checker u_owah_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .drive_low (result.drive_low),
  .busy_res  (result.busy_res),
  .done_res  (result.done_res),
  .status    (result.status),
  .echo_byte (result.echo_byte)
);

// ===== verif/one_wire_address_handoff_master_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_address_handoff_master_core_tb
// Drives tick and start words into the handoff master and checks every result
// word against a cycle-free model of the bus sequencer. Most handoffs are
// well-formed: the line goes high, the device answers presence and echoes the
// address. The rest miss presence, echo a wrong bit, hold the line low or are
// plain noise. Register settings run from near-zero timing up to all-maximum;
// the all-maximum setting only runs the wait for the line to go high.
// ----------------------------------------------------------------------------
module one_wire_address_handoff_master_core_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 9;

  typedef enum int {SET_ZERO, SET_SMALL, SET_LONG_LOW, SET_MAX} setting_t;
  typedef enum int {
    SEQ_CLEAN, SEQ_NO_PRESENCE, SEQ_BAD_ECHO, SEQ_STUCK_LOW, SEQ_NOISE
  } seq_kind_t;

  // --------------------------------------------------------------------------
  // Bus drive model and result store
  // --------------------------------------------------------------------------
  class drive_scoreboard_t;
    owah_pkg::cfg_t                  cfg;
    logic [3:0]                      phase;
    logic [owah_pkg::TIMER_BITS-1:0] ticks;
    logic [2:0]                      bit_idx;
    logic [7:0]                      addr_hold;
    logic [7:0]                      send_sh;
    logic [7:0]                      read_sh;
    logic [1:0]                      status_q;
    owah_pkg::res_word_t             expected_drive[$];
    int                              errors;
    int                              checked;
    int                              ended[4];

    function new();
      cfg       = owah_pkg::CFG_RESET;
      phase     = owah_pkg::PH_IDLE;
      ticks     = '0;
      bit_idx   = '0;
      addr_hold = '0;
      send_sh   = '0;
      read_sh   = '0;
      status_q  = owah_pkg::ST_OK;
      errors    = 0;
      checked   = 0;
      ended     = '{0, 0, 0, 0};
    endfunction

    // register write, truncated to the register width
    function void set_reg(logic [owah_pkg::REG_INDEX_W-1:0] idx,
                          logic [owah_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        owah_pkg::REG_RESET_LOW:      cfg.reset_low_us         = data[11:0];
        owah_pkg::REG_PRES_SAMPLE:    cfg.presence_sample_us   = data[9:0];
        owah_pkg::REG_PRES_RECOVER:   cfg.presence_recovery_us = data[9:0];
        owah_pkg::REG_WRITE_ONE_LOW:  cfg.write_one_low_us     = data[5:0];
        owah_pkg::REG_WRITE_ZERO_LOW: cfg.write_zero_low_us    = data[6:0];
        owah_pkg::REG_READ_SAMPLE:    cfg.read_sample_us       = data[5:0];
        owah_pkg::REG_SLOT:           cfg.slot_us              = data[7:0];
        default:                      cfg.idle_wait_limit_us   = data[19:0];
      endcase
    endfunction

    function void go(logic [3:0] ph);
      phase   = ph;
      ticks   = '0;
      bit_idx = '0;
    endfunction

    function void bump();
      if (ticks != owah_pkg::TIMER_MAX) ticks++;
    endfunction

    function logic drive_now();
      logic [7:0] low;
      case (phase)
        owah_pkg::PH_RESET_LOW: return 1'b1;
        owah_pkg::PH_WRITE_ADDR, owah_pkg::PH_WRITE_ACK: begin
          low = send_sh[bit_idx] ? 8'(cfg.write_one_low_us) : 8'(cfg.write_zero_low_us);
          return ticks < low;
        end
        owah_pkg::PH_READ_ECHO: return ticks < cfg.write_one_low_us;
        default: return 1'b0;
      endcase
    endfunction

    // one microsecond of sequencer time
    function void advance(logic line, output logic done);
      done = 1'b0;
      case (phase)
        owah_pkg::PH_WAIT_HIGH: begin
          if (ticks >= cfg.idle_wait_limit_us || ticks == owah_pkg::TIMER_MAX) begin
            status_q = owah_pkg::ST_STUCK_LOW;
            go(owah_pkg::PH_IDLE);
            done = 1'b1;
          end else begin
            bump();
            if (line) go(owah_pkg::PH_RESET_LOW);
          end
        end
        owah_pkg::PH_RESET_LOW: begin
          bump();
          if (ticks >= cfg.reset_low_us) go(owah_pkg::PH_PRES_WAIT);
        end
        owah_pkg::PH_PRES_WAIT: begin
          bump();
          if (ticks >= cfg.presence_sample_us) begin
            status_q = line ? owah_pkg::ST_NO_PRESENCE : owah_pkg::ST_OK;
            go(owah_pkg::PH_PRES_RECOVER);
          end
        end
        owah_pkg::PH_PRES_RECOVER: begin
          bump();
          if (ticks >= cfg.presence_recovery_us) begin
            if (status_q != owah_pkg::ST_OK) begin
              go(owah_pkg::PH_IDLE);
              done = 1'b1;
            end else begin
              send_sh = addr_hold;
              go(owah_pkg::PH_WRITE_ADDR);
            end
          end
        end
        owah_pkg::PH_WRITE_ADDR, owah_pkg::PH_READ_ECHO, owah_pkg::PH_WRITE_ACK: begin
          bump();
          if (phase == owah_pkg::PH_READ_ECHO && ticks == cfg.read_sample_us && line)
            read_sh[bit_idx] = 1'b1;
          if (ticks >= cfg.slot_us) begin
            ticks = '0;
            if (bit_idx != 3'd7) begin
              bit_idx++;
            end else if (phase == owah_pkg::PH_WRITE_ADDR) begin
              read_sh = '0;
              go(owah_pkg::PH_READ_ECHO);
            end else if (phase == owah_pkg::PH_READ_ECHO) begin
              if (read_sh == addr_hold) begin
                send_sh  = owah_pkg::ACK_MATCH;
                status_q = owah_pkg::ST_OK;
              end else begin
                send_sh  = owah_pkg::ACK_MISMATCH;
                status_q = owah_pkg::ST_MISMATCH;
              end
              go(owah_pkg::PH_WRITE_ACK);
            end else begin
              go(owah_pkg::PH_IDLE);
              done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (done) ended[status_q]++;
    endfunction

    // accepted input word: update the model and queue its result
    function void note_word(logic op, logic [7:0] addr, logic line);
      owah_pkg::res_word_t w;
      logic                done;
      done = 1'b0;
      if (op == owah_pkg::OP_START) begin
        if (phase == owah_pkg::PH_IDLE) begin
          addr_hold = addr;
          status_q  = owah_pkg::ST_OK;
          go(owah_pkg::PH_WAIT_HIGH);
        end
      end else begin
        advance(line, done);
      end
      w.drive_low = drive_now();
      w.busy_res  = (phase != owah_pkg::PH_IDLE);
      w.done_res  = done;
      w.status    = status_q;
      w.echo_byte = read_sh;
      expected_drive.push_back(w);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      if (errors <= 40)
        $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
    endtask

    task check_result(owah_pkg::res_word_t got);
      owah_pkg::res_word_t want;
      if (expected_drive.size() == 0) begin
        report("result with nothing pending", got.echo_byte, 8'h00);
        return;
      end
      want = expected_drive.pop_front();
      checked++;
      if (got.drive_low !== want.drive_low)
        report("drive_low", 8'(got.drive_low), 8'(want.drive_low));
      if (got.busy_res !== want.busy_res)
        report("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      if (got.done_res !== want.done_res)
        report("done_res", 8'(got.done_res), 8'(want.done_res));
      if (got.status !== want.status)
        report("status", 8'(got.status), 8'(want.status));
      if (got.echo_byte !== want.echo_byte)
        report("echo_byte", got.echo_byte, want.echo_byte);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic                             clk = 1'b0;
  logic                             rst;
  logic                             wr_en;
  logic [owah_pkg::REG_INDEX_W-1:0] wr_index;
  logic [owah_pkg::CFG_DATA_W-1:0]  wr_data;

  owah_in_if  item_ch ();
  owah_out_if res_ch ();

  drive_scoreboard_t sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int live_words;
  int settings_used;
  int idle_cycles;

  setting_t plan[NUM_PHASES] = '{SET_ZERO, SET_SMALL, SET_LONG_LOW, SET_SMALL, SET_MAX,
                                 SET_SMALL, SET_SMALL, SET_LONG_LOW, SET_SMALL};
  int       budget[NUM_PHASES] = '{20, 60, 50, 60, 40, 60, 60, 50, 60};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  one_wire_address_handoff_master_core u_top (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check and watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result('{drive_low: res_ch.drive_low, busy_res: res_ch.busy_res,
                          done_res: res_ch.done_res, status: res_ch.status,
                          echo_byte: res_ch.echo_byte});
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // present one word, with a random hold-off, and wait for it to be taken
  task send_word(logic op, logic [7:0] addr, logic line);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.address    <= addr;
    item_ch.line_level <= line;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    sb.note_word(op, addr, line);
  endtask

  task write_reg(logic [owah_pkg::REG_INDEX_W-1:0] idx,
                 logic [owah_pkg::CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // wait for every pending result, then let the block settle
  task drain();
    while (sb.expected_drive.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task apply_setting(setting_t kind);
    owah_pkg::cfg_t c;
    case (kind)
      SET_ZERO: c = '{12'd0, 10'd0, 10'd0, 6'd1, 7'd1, 6'd1, 8'd0, 20'd0};
      SET_MAX:  c = '1;
      SET_LONG_LOW: begin
        // low times and sample point at or past the slot end
        c.reset_low_us         = 12'($urandom_range(3));
        c.presence_sample_us   = 10'($urandom_range(3));
        c.presence_recovery_us = 10'($urandom_range(3));
        c.write_one_low_us     = 6'd63;
        c.write_zero_low_us    = 7'd127;
        c.read_sample_us       = 6'd63;
        c.slot_us              = 8'($urandom_range(8, 1));
        c.idle_wait_limit_us   = 20'($urandom_range(20, 1));
      end
      default: begin
        c.reset_low_us         = 12'($urandom_range(4));
        c.presence_sample_us   = 10'($urandom_range(4));
        c.presence_recovery_us = 10'($urandom_range(4));
        c.write_one_low_us     = 6'($urandom_range(4, 1));
        c.write_zero_low_us    = 7'($urandom_range(6, 1));
        c.read_sample_us       = 6'($urandom_range(5, 1));
        c.slot_us              = 8'($urandom_range(6, 1));
        c.idle_wait_limit_us   = 20'($urandom_range(40));
      end
    endcase
    write_reg(owah_pkg::REG_RESET_LOW, {8'd0, c.reset_low_us});
    write_reg(owah_pkg::REG_PRES_SAMPLE, {10'd0, c.presence_sample_us});
    write_reg(owah_pkg::REG_PRES_RECOVER, {10'd0, c.presence_recovery_us});
    write_reg(owah_pkg::REG_WRITE_ONE_LOW, {14'd0, c.write_one_low_us});
    write_reg(owah_pkg::REG_WRITE_ZERO_LOW, {13'd0, c.write_zero_low_us});
    write_reg(owah_pkg::REG_READ_SAMPLE, {14'd0, c.read_sample_us});
    write_reg(owah_pkg::REG_SLOT, {12'd0, c.slot_us});
    write_reg(owah_pkg::REG_IDLE_LIMIT, c.idle_wait_limit_us);
    wr_en <= 1'b0;
    settings_used++;
  endtask

  // line level for the next tick, shaped by where the sequencer is
  function logic pick_line(seq_kind_t kind, int flip);
    logic [owah_pkg::TIMER_BITS:0] nxt;
    nxt = {1'b0, sb.ticks} + 1'b1;
    if (kind == SEQ_NOISE) return 1'($urandom_range(1));
    case (sb.phase)
      owah_pkg::PH_WAIT_HIGH:
        return (kind == SEQ_STUCK_LOW) ? 1'b0 : ($urandom_range(3) == 0);
      owah_pkg::PH_PRES_WAIT:
        if (nxt >= sb.cfg.presence_sample_us) return kind == SEQ_NO_PRESENCE;
      owah_pkg::PH_READ_ECHO:
        if (nxt == sb.cfg.read_sample_us)
          return sb.addr_hold[sb.bit_idx] ^ (kind == SEQ_BAD_ECHO && flip == sb.bit_idx);
      default: ;
    endcase
    return 1'($urandom_range(1));
  endfunction

  // one handoff from start to done, with stray starts and idle ticks around it
  task run_handoff();
    seq_kind_t kind;
    int        roll;
    int        flip;
    roll = $urandom_range(99);
    flip = $urandom_range(7);
    if (roll < 55)      kind = SEQ_CLEAN;
    else if (roll < 65) kind = SEQ_NO_PRESENCE;
    else if (roll < 80) kind = SEQ_BAD_ECHO;
    else if (roll < 90)
      kind = (sb.cfg.idle_wait_limit_us <= 64) ? SEQ_STUCK_LOW : SEQ_CLEAN;
    else                kind = SEQ_NOISE;
    repeat ($urandom_range(2))
      send_word(owah_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)));
    send_word(owah_pkg::OP_START, 8'($urandom), 1'($urandom_range(1)));
    live_words++;
    while (sb.phase != owah_pkg::PH_IDLE) begin
      if ($urandom_range(99) < 2) begin
        send_word(owah_pkg::OP_START, 8'($urandom), 1'($urandom_range(1)));
      end else begin
        send_word(owah_pkg::OP_TICK, 8'($urandom), pick_line(kind, flip));
        live_words++;
      end
    end
  endtask

  // start under maximum timing and hold the line low; the wait carries on
  // into the next setting, which ends it
  task run_max_wait(int ticks);
    send_word(owah_pkg::OP_START, 8'($urandom), 1'b0);
    live_words++;
    repeat (ticks) begin
      send_word(owah_pkg::OP_TICK, 8'($urandom), 1'b0);
      live_words++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int first;
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.op         = owah_pkg::OP_TICK;
    item_ch.address    = '0;
    item_ch.line_level = 1'b0;
    res_ch.ready       = 1'b0;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    send_idle_pct      = 33;
    recv_idle_pct      = 49;
    live_words         = 0;
    settings_used      = 0;
    idle_cycles        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: idle ticks, start while busy, timeout with a zero limit
    apply_setting(SET_ZERO);
    send_word(owah_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(owah_pkg::OP_TICK, 8'hFF, 1'b1);
    send_word(owah_pkg::OP_START, 8'hFF, 1'b0);
    send_word(owah_pkg::OP_START, 8'h00, 1'b1);
    send_word(owah_pkg::OP_TICK, 8'hAA, 1'b0);
    send_word(owah_pkg::OP_TICK, 8'h55, 1'b1);
    item_ch.valid <= 1'b0;
    drain();

    // random handoffs over a run of register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 49;
      end else if (p < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(plan[p]);
      first = live_words;
      if (plan[p] == SET_MAX) begin
        run_max_wait(budget[p]);
      end else begin
        while (live_words - first < budget[p]) run_handoff();
      end
      item_ch.valid <= 1'b0;
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.expected_drive.size() != 0)
      sb.report("results never returned", 8'(sb.expected_drive.size()), 8'h00);
    $display("handoff run: %0d live words, %0d results checked, %0d register settings",
             live_words, sb.checked, settings_used);
    $display("handoffs ended: ok %0d, stuck low %0d, no presence %0d, echo mismatch %0d",
             sb.ended[owah_pkg::ST_OK], sb.ended[owah_pkg::ST_STUCK_LOW],
             sb.ended[owah_pkg::ST_NO_PRESENCE], sb.ended[owah_pkg::ST_MISMATCH]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
